// File: src/tslb_pkg.sv
// Shared types and constants of the tree scope list builder.
package tslb_pkg;

	// Depth of the open-node stack and width of kept labels.
	localparam int STACK_DEPTH = 32;
	localparam int LABEL_BITS  = 16;
	localparam int POS_W       = 16;

	localparam int STACK_AW = $clog2(STACK_DEPTH);
	localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);
	localparam logic [DEPTH_W-1:0] FULL_DEPTH = DEPTH_W'(STACK_DEPTH);

	// Request queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QUEUE_CW-1:0] QUEUE_FULL = QUEUE_CW'(QUEUE_DEPTH);
	localparam logic [QUEUE_AW-1:0] QUEUE_LAST = QUEUE_AW'(QUEUE_DEPTH - 1);

	localparam logic [POS_W-1:0] POS_MAX = '1;

	typedef struct packed {
		logic [23:0] tree_id;
		logic        is_backtrack;
		logic [15:0] item_label;
		logic        last_token;
	} token_t;

	typedef struct packed {
		logic [23:0] out_tree_id;
		logic [15:0] out_label;
		logic [15:0] start_pos;
		logic [15:0] end_pos;
		logic        error_flag;
		logic        last_of_run;
	} record_t;

	typedef enum logic {
		OP_PUSH,
		OP_POP
	} cmd_op_t;

	typedef struct packed {
		logic [23:0]           tree_id;
		cmd_op_t               op;
		logic [LABEL_BITS-1:0] label;
		logic                  last;
	} cmd_t;

	typedef struct packed {
		logic [LABEL_BITS-1:0] label;
		logic [POS_W-1:0]      start;
	} node_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} back_state_t;

endpackage

// File: src/tree_scope_list_builder_top.sv
// Top level of the tree scope list builder: front end, request queue, stack back end.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  tok     | in        | tok_valid / tok_ready | tslb_pkg::token_t  (one token)
//  rec     | out       | rec_valid / rec_ready | tslb_pkg::record_t (one closed node)
//
//  The front takes one token request per cycle, unless full, into a 4-entry queue.
//  While idle the back pulls one queued request per cycle for labels and
//  empty backtracks; each closed node then takes two more states (stack
//  memory read, record load). A last token drains every open node this way;
//  the queue keeps taking tokens meanwhile.
//  Reset (arst_n) clears counters, queue pointers and valid flags at once;
//  the stack memory is not cleared, only entries below the depth are read.
//  A stall on rec holds the back in its record state; tok stalls only when
//  the queue is full.
module tree_scope_list_builder_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_valid,
	output logic              tok_ready,
	input  tslb_pkg::token_t  tok,
	output logic              rec_valid,
	input  logic              rec_ready,
	output tslb_pkg::record_t rec
);

	// queued stack request between the two halves
	logic           q_valid;
	logic           q_pop;
	tslb_pkg::cmd_t q_cmd;

	// front: classify token into push / pop request
	tslb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok       (tok),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_cmd     (q_cmd)
	);

	// back: stack, preorder numbering, record output register
	tslb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_cmd     (q_cmd),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec       (rec)
	);

endmodule

// File: src/tslb_front.sv
// Front end: accepts tokens, classifies them into stack requests and queues them.
module tslb_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tok_valid,
	output logic            tok_ready,
	input  tslb_pkg::token_t tok,
	output logic            q_valid,
	input  logic            q_pop,
	output tslb_pkg::cmd_t  q_cmd
);

	tslb_pkg::cmd_t                    queue_q [tslb_pkg::QUEUE_DEPTH];
	logic [tslb_pkg::QUEUE_AW-1:0]     head_q;
	logic [tslb_pkg::QUEUE_AW-1:0]     tail_q;
	logic [tslb_pkg::QUEUE_CW-1:0]     count_q;
	tslb_pkg::cmd_t                    cmd_in;
	logic                              push;
	logic                              pop;

	assign tok_ready = (count_q != tslb_pkg::QUEUE_FULL);
	assign push      = tok_valid && tok_ready;
	assign pop       = q_pop && q_valid;
	assign q_valid   = (count_q != '0);
	assign q_cmd     = queue_q[head_q];

	// classify: backtrack vs. label, keep only the stored label bits
	always_comb begin
		cmd_in.tree_id = tok.tree_id;
		cmd_in.op      = tok.is_backtrack ? tslb_pkg::OP_POP : tslb_pkg::OP_PUSH;
		cmd_in.label   = tok.item_label[tslb_pkg::LABEL_BITS-1:0];
		cmd_in.last    = tok.last_token;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[tail_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == tslb_pkg::QUEUE_LAST) ? '0 : tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= (head_q == tslb_pkg::QUEUE_LAST) ? '0 : head_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/tslb_back.sv
// Back end: open-node stack, preorder numbering and record output register.
module tslb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_pop,
	input  tslb_pkg::cmd_t    q_cmd,
	output logic              rec_valid,
	input  logic              rec_ready,
	output tslb_pkg::record_t rec
);

	tslb_pkg::node_t                   stack_mem [tslb_pkg::STACK_DEPTH];
	tslb_pkg::node_t                   rd_q;
	tslb_pkg::back_state_t             state_q;
	tslb_pkg::back_state_t             state_d;
	logic [tslb_pkg::DEPTH_W-1:0]      depth_q;
	logic [tslb_pkg::DEPTH_W-1:0]      depth_d;
	logic [tslb_pkg::POS_W-1:0]        pos_q;
	logic [tslb_pkg::POS_W-1:0]        pos_d;
	logic                              ovf_q;
	logic                              ovf_d;
	logic                              drain_q;
	logic                              drain_d;
	logic [23:0]                       tid_q;
	logic [23:0]                       tid_d;
	logic                              mem_we;
	logic                              rd_en;
	logic                              rec_load;
	logic [tslb_pkg::DEPTH_W-1:0]      depth_dec;
	tslb_pkg::record_t                 rec_q;
	tslb_pkg::record_t                 rec_d;
	logic                              rec_valid_q;

	assign depth_dec = depth_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tslb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		depth_d  = depth_q;
		pos_d    = pos_q;
		ovf_d    = ovf_q;
		drain_d  = drain_q;
		tid_d    = tid_q;
		q_pop    = 1'b0;
		mem_we   = 1'b0;
		rd_en    = 1'b0;
		rec_load = 1'b0;
		unique case (state_q)
			tslb_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					tid_d = q_cmd.tree_id;
					if (q_cmd.op == tslb_pkg::OP_PUSH) begin
						// numbered always, stored only if there is room
						if (depth_q != tslb_pkg::FULL_DEPTH) begin
							mem_we  = 1'b1;
							depth_d = depth_q + 1'b1;
						end else begin
							ovf_d = 1'b1;
						end
						if (pos_q == tslb_pkg::POS_MAX) begin
							ovf_d = 1'b1;
						end
						pos_d = pos_q + 1'b1;
						if (q_cmd.last) begin
							drain_d = 1'b1;
							state_d = tslb_pkg::ST_READ;
						end
					end else begin
						if (depth_q != '0) begin
							drain_d = q_cmd.last;
							state_d = tslb_pkg::ST_READ;
						end else if (q_cmd.last) begin
							pos_d = '0;
							ovf_d = 1'b0;
						end
					end
				end
			end
			tslb_pkg::ST_READ: begin
				rd_en   = 1'b1;
				depth_d = depth_dec;
				state_d = tslb_pkg::ST_EMIT;
			end
			tslb_pkg::ST_EMIT: begin
				if (!rec_valid_q || rec_ready) begin
					rec_load = 1'b1;
					if (drain_q && depth_q != '0) begin
						state_d = tslb_pkg::ST_READ;
					end else begin
						if (drain_q) begin
							pos_d = '0;
							ovf_d = 1'b0;
						end
						drain_d = 1'b0;
						state_d = tslb_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = tslb_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		rec_d.out_tree_id = tid_q;
		rec_d.out_label   = 16'(rd_q.label);
		rec_d.start_pos   = rd_q.start;
		rec_d.end_pos     = pos_q - 1'b1;
		rec_d.error_flag  = ovf_q;
		rec_d.last_of_run = drain_q && (depth_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			pos_q       <= '0;
			ovf_q       <= 1'b0;
			drain_q     <= 1'b0;
			rec_valid_q <= 1'b0;
		end else begin
			depth_q <= depth_d;
			pos_q   <= pos_d;
			ovf_q   <= ovf_d;
			drain_q <= drain_d;
			if (rec_load) begin
				rec_valid_q <= 1'b1;
			end else if (rec_ready) begin
				rec_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tid_q <= tid_d;
		if (rec_load) begin
			rec_q <= rec_d;
		end
	end

	// stack memory, registered read of the top entry
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[depth_q[tslb_pkg::STACK_AW-1:0]] <= '{label: q_cmd.label, start: pos_q};
		end
		if (rd_en) begin
			rd_q <= stack_mem[depth_dec[tslb_pkg::STACK_AW-1:0]];
		end
	end

	assign rec_valid = rec_valid_q;
	assign rec       = rec_q;

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= tslb_pkg::FULL_DEPTH)
		else $error("stack depth above capacity");

	a_no_wr_rd: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && rd_en))
		else $error("stack write and read in one cycle");

	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> depth_q != '0)
		else $error("pop from empty stack");

	a_run_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_load && rec_d.last_of_run) |=> (pos_q == '0 && !ovf_q && depth_q == '0))
		else $error("tree state not cleared after last record");
`endif

endmodule
